// ===== rtl/erg_pkg.sv =====
// Shared constants and controller/datapath command and status types.
`default_nettype none

package erg_pkg;

    localparam int MAX_STEPS = 32;
    localparam int STEP_W    = $clog2(MAX_STEPS);   // step index width
    localparam int CNT_W     = 6;                   // pulse/step count field width
    localparam int ROT_W     = 7;                   // rotation field width

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture a request
        logic bucket;   // one bucket step
        logic reduce;   // one rotation reduction step
        logic align;    // fix the read start
        logic emit;     // load the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic zero_req;     // request with zero steps
        logic bucket_last;  // bucket on the final step
        logic rot_done;     // rotation reduced below the step count
        logic out_free;     // output register can take a word
        logic emit_last;    // next word emitted is the final one
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/erg_if.sv =====
// Request and step channel interfaces.
`default_nettype none

interface erg_in_if;
    import erg_pkg::*;
    logic               valid;
    logic               ready;
    logic [CNT_W-1:0]   pulse_count;
    logic [CNT_W-1:0]   step_count;
    logic signed [ROT_W-1:0] rotate_by;

    modport source (output valid, output pulse_count, output step_count,
                    output rotate_by, input ready);
    modport sink   (input valid, input pulse_count, input step_count,
                    input rotate_by, output ready);
endinterface

interface erg_out_if;
    import erg_pkg::*;
    logic               valid;
    logic               ready;
    logic [STEP_W-1:0]  step_index;
    logic               hit;
    logic               last;

    modport source (output valid, output step_index, output hit, output last,
                    input ready);
    modport sink   (input valid, input step_index, input hit, input last,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/euclidean_rhythm_generator.sv =====
// Top level: Euclidean rhythm generator, controller plus datapath.
//
//  Channel   Dir  Word fields                               Handshake
//  i_in      in   pulse_count[5:0] step_count[5:0]          valid/ready
//                 rotate_by[6:0] (signed)
//  o_out     out  step_index[4:0] hit last                  valid/ready
//
//  Sequence: the accept, then n bucket steps (n = step count, capped at 32) with the
//  rotation magnitude cut by n once a cycle alongside; reduction steps left over after the
//  bucket pass (floor(|rotate_by|/n) - n, when positive) run in the alignment state; then
//  the alignment and n words out at one a cycle while the output register is free.
//  A zero step count is taken and dropped.
//  Reset: synchronous, active low; clears the state machine, the output valid, the bucket
//  and the step position.
//  Stalls: the output register holds a word until taken; emission pauses meanwhile.
//  A new request is taken as soon as the final word sits in the output register.
`default_nettype none

module euclidean_rhythm_generator
    import erg_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    erg_in_if.sink     i_in,
    erg_out_if.source  o_out
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    // sequencing
    erg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // bucket, rotation, pattern and output word
    erg_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pulse_count (i_in.pulse_count),
        .i_step_count  (i_in.step_count),
        .i_rotate_by   (i_in.rotate_by),
        .i_out_ready   (o_out.ready),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_out_valid   (o_out.valid),
        .o_step_index  (o_out.step_index),
        .o_hit         (o_out.hit),
        .o_last        (o_out.last)
    );

    assign i_in.ready = w_in_ready;

endmodule

`default_nettype wire

// ===== rtl/erg_ctrl.sv =====
// Sequencing state machine: accept, bucket pass, alignment, emission.
`default_nettype none

module erg_ctrl
    import erg_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_BUCKET = 2'd1;
    localparam logic [1:0] ST_ALIGN  = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && !i_sts.zero_req) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_BUCKET;
                end
            end
            ST_BUCKET: begin
                o_cmd.bucket = 1'b1;
                o_cmd.reduce = 1'b1;
                if (i_sts.bucket_last) begin
                    n_state = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                o_cmd.reduce = 1'b1;
                if (i_sts.rot_done) begin
                    o_cmd.align = 1'b1;
                    n_state     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_cmd.emit = i_sts.out_free;
                if (i_sts.out_free && i_sts.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // the final word always hands control back for the next request
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_sts.emit_last) |=> (r_state == ST_IDLE))
        else $error("controller did not return to idle after final word");

    // alignment only once the rotation has been reduced
    a_align_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.align |-> i_sts.rot_done)
        else $error("alignment before rotation reduced");

    // a new request never starts while emission is in progress
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> !o_cmd.load && !o_in_ready)
        else $error("request taken during emission");

endmodule

`default_nettype wire

// ===== rtl/erg_dp.sv =====
// Bucket accumulator, rotation reduction, pattern store and output register.
`default_nettype none

module erg_dp
    import erg_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire [CNT_W-1:0]    i_pulse_count,
    input  wire [CNT_W-1:0]    i_step_count,
    input  wire [ROT_W-1:0]    i_rotate_by,
    input  wire                i_out_ready,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic               o_out_valid,
    output logic [STEP_W-1:0]  o_step_index,
    output logic               o_hit,
    output logic               o_last
);

    logic [CNT_W-1:0]     r_n;        // saturated step count, 1..MAX_STEPS
    logic [CNT_W-1:0]     r_p;        // saturated pulse count
    logic [CNT_W-1:0]     r_acc;
    logic [STEP_W-1:0]    r_cnt;
    logic [STEP_W-1:0]    r_first;
    logic                 r_any;
    logic [MAX_STEPS-1:0] r_raw;      // unrotated pattern
    logic [ROT_W-1:0]     r_rot;
    logic                 r_neg;
    logic [STEP_W-1:0]    r_rd;
    logic [STEP_W-1:0]    r_pos;
    logic                 r_ovalid;
    logic [STEP_W-1:0]    r_idx;
    logic                 r_hit;
    logic                 r_last;

    logic [CNT_W-1:0] n_n;
    logic [CNT_W-1:0] n_p;
    logic [ROT_W-1:0] n_mag;
    logic [CNT_W:0]   n_bsum;
    logic             n_bhit;
    logic [CNT_W-1:0] n_last_pos;
    logic [CNT_W-1:0] n_rotf;
    logic [CNT_W-1:0] n_ssum;
    logic [CNT_W-1:0] n_shift;

    always_comb begin
        n_n = (i_step_count > CNT_W'(MAX_STEPS)) ? CNT_W'(MAX_STEPS) : i_step_count;
        n_p = (i_pulse_count > n_n) ? n_n : i_pulse_count;
        // magnitude of the rotation; -64 maps to 64
        n_mag = i_rotate_by[ROT_W-1] ? (ROT_W'(0) - i_rotate_by) : i_rotate_by;

        n_bsum = {1'b0, r_acc} + {1'b0, r_p};
        n_bhit = (n_bsum >= {1'b0, r_n});
        n_last_pos = r_n - CNT_W'(1);

        // right rotation becomes a left rotation by the complement
        n_rotf = (r_neg && (r_rot != '0)) ? (r_n - r_rot[CNT_W-1:0]) : r_rot[CNT_W-1:0];
        n_ssum = (r_any ? {1'b0, r_first} : CNT_W'(0)) + n_rotf;
        n_shift = (n_ssum >= r_n) ? (n_ssum - r_n) : n_ssum;

        o_sts.zero_req    = (i_step_count == '0);
        o_sts.bucket_last = ({1'b0, r_cnt} == n_last_pos);
        o_sts.rot_done    = (r_rot < {1'b0, r_n});
        o_sts.out_free    = !r_ovalid || i_out_ready;
        o_sts.emit_last   = ({1'b0, r_pos} == n_last_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_pos <= '0;
        end else begin
            if (i_cmd.load) begin
                r_n     <= n_n;
                r_p     <= n_p;
                r_rot   <= n_mag;
                r_neg   <= i_rotate_by[ROT_W-1];
                r_acc   <= '0;
                r_cnt   <= '0;
                r_first <= '0;
                r_any   <= 1'b0;
            end else begin
                if (i_cmd.bucket) begin
                    r_raw[r_cnt] <= n_bhit;
                    r_acc        <= n_bhit ? CNT_W'(n_bsum - {1'b0, r_n})
                                           : n_bsum[CNT_W-1:0];
                    r_cnt        <= r_cnt + STEP_W'(1);
                    if (n_bhit && !r_any) begin
                        r_any   <= 1'b1;
                        r_first <= r_cnt;
                    end
                end
                if (i_cmd.reduce && !o_sts.rot_done) begin
                    r_rot <= r_rot - {1'b0, r_n};
                end
            end
            if (i_cmd.align) begin
                r_rd  <= n_shift[STEP_W-1:0];
                r_pos <= '0;
            end else if (i_cmd.emit) begin
                r_idx  <= r_pos;
                r_hit  <= r_raw[r_rd];
                r_last <= o_sts.emit_last;
                r_pos  <= r_pos + STEP_W'(1);
                r_rd   <= ({1'b0, r_rd} == n_last_pos) ? '0 : (r_rd + STEP_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid  = r_ovalid;
    assign o_step_index = r_idx;
    assign o_hit        = r_hit;
    assign o_last       = r_last;

    // bucket stays below the step count between steps
    a_bucket_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.bucket |-> (r_acc < r_n))
        else $error("bucket out of range");

    // read pointer stays inside the pattern
    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> ({1'b0, r_rd} < r_n))
        else $error("read pointer past pattern end");

    // a word with the last flag is the final position of the pattern
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && o_sts.emit_last) |=> (r_last && ({1'b0, r_idx} == r_n - CNT_W'(1))))
        else $error("last flag on wrong step");

endmodule

`default_nettype wire

// ===== sim/erg_step_checker.sv =====
// Step stream checker: predicts each rhythm pattern and compares the step words.
`timescale 1ns / 100ps

module erg_step_checker
    import erg_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_req_valid,
    input  wire                    i_req_ready,
    input  wire [CNT_W-1:0]        i_pulse_count,
    input  wire [CNT_W-1:0]        i_step_count,
    input  wire signed [ROT_W-1:0] i_rotate_by,
    input  wire                    i_step_valid,
    input  wire                    i_step_ready,
    input  wire [STEP_W-1:0]       i_step_index,
    input  wire                    i_hit,
    input  wire                    i_last,
    output int                     o_mismatches,
    output int                     o_steps_due
);

    typedef struct packed {
        logic [STEP_W-1:0] index;
        logic              hit;
        logic              last;
    } step_word_t;

    step_word_t steps_due[$];
    int         mismatches = 0;

    assign o_mismatches = mismatches;
    assign o_steps_due  = steps_due.size();

    // Bucket pass, first-hit alignment, then the signed rotation folded into one left shift.
    task automatic predict_rhythm(input logic [CNT_W-1:0] pulses,
                                  input logic [CNT_W-1:0] steps,
                                  input logic signed [ROT_W-1:0] rot);
        int                   n;
        int                   p;
        int                   bucket;
        int                   first;
        int                   turn;
        int                   shift;
        bit                   found;
        logic [MAX_STEPS-1:0] raw;
        step_word_t           w;
        n = (steps > MAX_STEPS) ? MAX_STEPS : int'(steps);
        if (n == 0) return;
        p      = (int'(pulses) > n) ? n : int'(pulses);
        bucket = 0;
        first  = 0;
        found  = 0;
        raw    = '0;
        for (int i = 0; i < n; i++) begin
            if (p != 0) begin
                bucket += p;
                if (bucket >= n) begin
                    bucket -= n;
                    raw[i] = 1'b1;
                    if (!found) begin
                        found = 1;
                        first = i;
                    end
                end
            end
        end
        turn = int'(rot);
        if (turn < 0) begin
            turn = (-turn) % n;
            if (turn != 0) turn = n - turn;
        end else begin
            turn = turn % n;
        end
        shift = (first + turn) % n;
        for (int i = 0; i < n; i++) begin
            w.index   = STEP_W'(i);
            w.hit     = raw[(i + shift) % n];
            w.last    = (i == n - 1);
            steps_due = {steps_due, w};
        end
    endtask

    always @(posedge i_clk) begin : watch
        step_word_t want;
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready)
                predict_rhythm(i_pulse_count, i_step_count, i_rotate_by);
            if (i_step_valid && i_step_ready) begin
                if (steps_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: step word expected none, got index %0d hit %b last %b",
                             $time, i_step_index, i_hit, i_last);
                end else begin
                    want = steps_due.pop_front();
                    if (i_step_index !== want.index) begin
                        mismatches++;
                        $display("%0t: step_index expected %0d, got %0d",
                                 $time, want.index, i_step_index);
                    end
                    if (i_hit !== want.hit) begin
                        mismatches++;
                        $display("%0t: hit at step %0d expected %b, got %b",
                                 $time, want.index, want.hit, i_hit);
                    end
                    if (i_last !== want.last) begin
                        mismatches++;
                        $display("%0t: last at step %0d expected %b, got %b",
                                 $time, want.index, want.last, i_last);
                    end
                end
            end
        end
    end

endmodule

// ===== sim/euclidean_rhythm_generator_tb.sv =====
// Testbench top: drives rhythm requests and step back-pressure, gives the verdict.
`timescale 1ns / 100ps

module euclidean_rhythm_generator_tb
    import erg_pkg::*;
();

    localparam int RANDOM_REQUESTS = 140;
    localparam int DRAIN_AT        = 80;    // random request before which the sender waits for a drain
    localparam int HOLD_AT_WORD    = 60;    // step word before which the receiver holds off
    localparam int HOLD_CYCLES     = 300;
    localparam int TAIL_CYCLES     = 100;
    localparam int WATCHDOG_LIMIT  = 2000;  // hold-off + gaps + latency, several times over

    logic i_clk;
    logic i_rst_n;

    erg_in_if  req_ch ();
    erg_out_if step_ch ();

    int mismatches;
    int steps_due;
    bit send_idle;
    bit recv_idle;
    int quiet_cycles;

    euclidean_rhythm_generator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (step_ch)
    );

    erg_step_checker step_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (req_ch.valid),
        .i_req_ready   (req_ch.ready),
        .i_pulse_count (req_ch.pulse_count),
        .i_step_count  (req_ch.step_count),
        .i_rotate_by   (req_ch.rotate_by),
        .i_step_valid  (step_ch.valid),
        .i_step_ready  (step_ch.ready),
        .i_step_index  (step_ch.step_index),
        .i_hit         (step_ch.hit),
        .i_last        (step_ch.last),
        .o_mismatches  (mismatches),
        .o_steps_due   (steps_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: any accepted word on either channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (step_ch.valid && step_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // One request word. Entered just after an accept edge (or reset release); the
    // next falling edge either lowers valid for a gap or puts up the next word, so
    // valid is never dropped and raised in the same step.
    task automatic send_request(input int pulses, input int steps, input int turn);
        int gap;
        gap = send_idle ? $urandom_range(0, 16) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.pulse_count <= CNT_W'(pulses);
        req_ch.step_count  <= CNT_W'(steps);
        req_ch.rotate_by   <= ROT_W'(turn);
        req_ch.valid       <= 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Stop offering and let every predicted step word come out.
    task automatic drain_steps();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        wait (steps_due == 0);
        @(negedge i_clk);
    endtask

    // Sender
    initial begin
        int n;
        int p;
        int r;
        i_rst_n            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.pulse_count = '0;
        req_ch.step_count  = '0;
        req_ch.rotate_by   = '0;
        send_idle          = 1'b1;
        quiet_cycles       = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty and full patterns, classic spreads, both rotation
        // directions and their extremes, shortest and longest patterns, step
        // counts past the top (saturated) and a zero step count (dropped).
        send_request( 0,  8,   0);    // no pulses
        send_request( 0,  8,   5);    // no pulses, rotation invisible
        send_request( 8,  8,   0);    // all hits
        send_request(63,  8,  -3);    // pulses saturate to the step count
        send_request( 3,  8,   0);
        send_request( 3,  8,   1);
        send_request( 3,  8,  -1);
        send_request( 5,  8,   2);
        send_request( 1,  1,   0);    // single step
        send_request( 0,  1,  63);
        send_request( 1,  1, -64);    // longest rotation reduction
        send_request(32, 32,   0);
        send_request( 5, 32, -32);
        send_request( 7, 32,  32);
        send_request(13, 32,  31);
        send_request( 5, 63,   3);    // step count saturates
        send_request( 9, 40,  -7);
        send_request( 5,  0,   3);    // zero steps: no words
        send_request( 0,  0, -64);
        send_request( 3,  7, -64);
        send_request( 4,  9,  63);
        send_request(63, 63,  -1);    // every input bit high
        send_request( 2,  5, -13);

        // Random: mostly in-range patterns, a fifth raw bit patterns over the whole fields.
        for (int k = 0; k < RANDOM_REQUESTS; k++) begin
            if (k % 20 == 0)
                send_idle = ($urandom_range(0, 2) != 0);
            if (k == DRAIN_AT)
                drain_steps();
            if ($urandom_range(0, 4) == 0) begin
                p = $urandom_range(0, 63);
                n = $urandom_range(0, 63);
            end else begin
                n = $urandom_range(1, MAX_STEPS);
                p = $urandom_range(0, n);
            end
            r = $urandom_range(0, 127);
            send_request(p, n, r);
        end

        drain_steps();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Receiver: random hold-off per step word, quiet stretches, and one long
    // hold-off so the output register backs up and the request channel stalls.
    initial begin
        int words;
        int gap;
        step_ch.ready = 1'b0;
        recv_idle     = 1'b1;
        words         = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (words % 25 == 0)
                recv_idle = ($urandom_range(0, 2) != 0);
            gap = recv_idle ? $urandom_range(0, 16) : 0;
            if (words == HOLD_AT_WORD)
                gap = HOLD_CYCLES;
            if (gap > 0) begin
                step_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            step_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!step_ch.valid);
            words++;
        end
    end

endmodule

// ===== sim.f =====
rtl/erg_pkg.sv
rtl/erg_if.sv
rtl/erg_ctrl.sv
rtl/erg_dp.sv
rtl/euclidean_rhythm_generator.sv
sim/erg_step_checker.sv
sim/euclidean_rhythm_generator_tb.sv
